// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RCFP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define RCFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/rcfp_pkg.sv =====
package rcfp_pkg;

   localparam int FRAME_LEN = 64;
   localparam int CNT_W     = $clog2(FRAME_LEN + 1);

   localparam logic [7:0] CH_OPEN   = 8'h7B;
   localparam logic [7:0] CH_CLOSE  = 8'h7D;
   localparam logic [7:0] CH_TURN   = 8'h4B;
   localparam logic [7:0] CH_LEAVE1 = 8'h49;
   localparam logic [7:0] CH_LEAVE2 = 8'h4A;
   localparam logic [7:0] CH_REPORT = 8'h50;
   localparam logic [7:0] CH_SAVE   = 8'h57;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_LAST_ID = 8'h36;
   localparam logic [7:0] CH_DIR_LO = 8'h41;
   localparam logic [7:0] CH_DIR_HI = 8'h48;
   localparam logic [7:0] CH_RIGHT  = 8'h43;
   localparam logic [7:0] CH_LEFT   = 8'h47;
   localparam logic [7:0] CH_FWD    = 8'h45;
   localparam logic [7:0] RAW_DIR_HI = 8'h08;
   localparam logic [7:0] DIGIT_BIAS = 8'd48;

   localparam logic [3:0] DIR_STOP  = 4'd0;
   localparam logic [3:0] DIR_MAX   = 4'd8;
   localparam logic [2:0] PARAM_MAX = 3'd6;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_PARAM  = 2'd1,
      EV_REPORT = 2'd2,
      EV_SAVE   = 2'd3
   } event_type;

endpackage

// ===== rtl/remote_command_frame_parser_core.sv =====
// Channel    | Ports                          | Handshake
// -----------+--------------------------------+--------------------------
// request    | req_valid/ready, req_rx_byte   | valid/ready, accepted when both high
// response   | rsp_valid/ready, rsp_* fields  | valid/ready, accepted when both high
// config     | csr_wr_en, csr_wr_data         | write on enable, no wait
//
// One request per cycle sustained while responses are taken; a request passes
// through the input register, then the result register, before rsp_valid rises.
// Parsing state advances only when the input register moves into the result
// register, so a stalled response holds one request in the input register.
// Reset (synchronous, active high) clears all parse and direction state.
// req_ready stays high while the input register is empty or can advance.
module remote_command_frame_parser_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_rx_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [3:0]              rsp_direction,
   output logic                    rsp_turn_left,
   output logic                    rsp_turn_right,
   output logic                    rsp_turn_mode,
   output logic [1:0]              rsp_event_res,
   output logic [2:0]              rsp_param_id,
   output logic signed [31:0]      rsp_param_value,
   input  logic                    csr_wr_en,
   input  logic                    csr_wr_data
);
   import rcfp_pkg::*;

   localparam logic [CNT_W-1:0] FRAME_LEN_C = CNT_W'(FRAME_LEN);
   localparam logic [CNT_W-1:0] IDX_ID      = CNT_W'(1);
   localparam logic [CNT_W-1:0] IDX_TAG     = CNT_W'(3);

   // configuration
   logic run_mode_ff;

   // input stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // direction state
   logic       turn_ff, turn_in;
   logic [3:0] dir_ff, dir_in;
   logic       left_ff, left_in;
   logic       right_ff, right_in;

   // frame state
   logic             coll_ff, coll_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       id_ff, id_in;
   logic [7:0]       tag_ff, tag_in;
   logic [31:0]      acc_ff, acc_in;

   // result stage
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_dir_ff;
   logic        rsp_left_ff, rsp_right_ff, rsp_turn_ff;
   event_type   rsp_ev_ff, ev_in;
   logic [2:0]  rsp_pid_ff, pid_in;
   logic [31:0] rsp_pval_ff, pval_in;

   logic       advance;
   logic       req_accept;
   logic [7:0] b;
   logic       open_start;
   logic       coll_eff;
   logic [CNT_W-1:0] cnt_eff;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;
   assign b          = in_byte_ff;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   // Direction and turn decoding; turn mode updates before direction sees the byte.
   always_comb begin
      turn_in  = turn_ff;
      dir_in   = dir_ff;
      left_in  = left_ff;
      right_in = right_ff;
      if (b == CH_TURN) begin
         turn_in = 1'b1;
      end else if (b == CH_LEAVE1 || b == CH_LEAVE2) begin
         turn_in = 1'b0;
      end
      if (!run_mode_ff) begin
         if (!turn_in) begin
            if (b >= CH_DIR_LO && b <= CH_DIR_HI) begin
               dir_in = b[3:0];
            end else if (b <= RAW_DIR_HI) begin
               dir_in = b[3:0];
            end else begin
               dir_in = DIR_STOP;
            end
         end else begin
            left_in  = (b == CH_LEFT);
            right_in = (b == CH_RIGHT);
            if (b == CH_DIR_LO || b == CH_FWD) begin
               dir_in = b[3:0];
            end else begin
               dir_in = DIR_STOP;
            end
         end
      end
   end

   // Frame collection and event decision.
   assign open_start = (b == CH_OPEN) && !coll_ff;
   assign coll_eff   = coll_ff || open_start;
   assign cnt_eff    = open_start ? '0 : cnt_ff;

   always_comb begin
      coll_in = coll_eff;
      cnt_in  = cnt_eff;
      id_in   = id_ff;
      tag_in  = tag_ff;
      acc_in  = acc_ff;
      ev_in   = EV_NONE;
      pid_in  = '0;
      pval_in = '0;
      if (b == CH_CLOSE) begin
         if (tag_ff == CH_REPORT) begin
            ev_in = EV_REPORT;
         end else if (tag_ff == CH_SAVE) begin
            ev_in = EV_SAVE;
         end else if (id_ff != CH_HASH && id_ff >= CH_ZERO && id_ff <= CH_LAST_ID) begin
            ev_in   = EV_PARAM;
            pid_in  = 3'(id_ff - CH_ZERO);
            pval_in = acc_ff;
         end
         // drop the frame back to idle
         coll_in = 1'b0;
         cnt_in  = '0;
         id_in   = '0;
         tag_in  = '0;
         acc_in  = '0;
      end else if (coll_eff && cnt_eff < FRAME_LEN_C) begin
         if (cnt_eff == IDX_ID) begin
            id_in = b;
         end
         if (cnt_eff == IDX_TAG) begin
            tag_in = b;
         end
         if (cnt_eff >= IDX_TAG) begin
            // value * 10 + byte - 48, wrapping in 32 bits
            acc_in = {acc_ff[28:0], 3'b000} + {acc_ff[30:0], 1'b0}
                   + {24'd0, b} - {24'd0, DIGIT_BIAS};
         end
         cnt_in = cnt_eff + CNT_W'(1);
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_mode_ff  <= 1'b0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         turn_ff      <= 1'b0;
         dir_ff       <= DIR_STOP;
         left_ff      <= 1'b0;
         right_ff     <= 1'b0;
         coll_ff      <= 1'b0;
         cnt_ff       <= '0;
         id_ff        <= '0;
         tag_ff       <= '0;
         acc_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            run_mode_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            turn_ff  <= turn_in;
            dir_ff   <= dir_in;
            left_ff  <= left_in;
            right_ff <= right_in;
            coll_ff  <= coll_in;
            cnt_ff   <= cnt_in;
            id_ff    <= id_in;
            tag_ff   <= tag_in;
            acc_ff   <= acc_in;
         end
      end
   end

   // payload registers: hold until advanced
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         rsp_dir_ff   <= dir_in;
         rsp_left_ff  <= left_in;
         rsp_right_ff <= right_in;
         rsp_turn_ff  <= turn_in;
         rsp_ev_ff    <= ev_in;
         rsp_pid_ff   <= pid_in;
         rsp_pval_ff  <= pval_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_direction   = rsp_dir_ff;
   assign rsp_turn_left   = rsp_left_ff;
   assign rsp_turn_right  = rsp_right_ff;
   assign rsp_turn_mode   = rsp_turn_ff;
   assign rsp_event_res   = rsp_ev_ff;
   assign rsp_param_id    = rsp_pid_ff;
   assign rsp_param_value = signed'(rsp_pval_ff);

endmodule

// ===== rtl/rcfp_checker.sv =====
`include "assert_macros.svh"

module rcfp_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [3:0]         rsp_direction,
   input logic               rsp_turn_left,
   input logic               rsp_turn_right,
   input logic [1:0]         rsp_event_res,
   input logic [2:0]         rsp_param_id,
   input logic signed [31:0] rsp_param_value
);
   import rcfp_pkg::*;

   // only a parameter write carries an id and a value
   `RCFP_ASSERT_NOW(a_no_stray_param, clock, reset, rsp_valid && rsp_event_res != EV_PARAM, rsp_param_id == 3'd0 && rsp_param_value == 32'sd0)
   // parameter writes address parameters 0..6 only
   `RCFP_ASSERT_NOW(a_param_range, clock, reset, rsp_valid && rsp_event_res == EV_PARAM, rsp_param_id <= PARAM_MAX)
   // the two turn flags are never set together, and direction stays in range
   `RCFP_ASSERT_NOW(a_flags_dir, clock, reset, rsp_valid, !(rsp_turn_left && rsp_turn_right) && rsp_direction <= DIR_MAX)
   // a stalled response stays valid and holds its event and value
   `RCFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_param_value) && $stable(rsp_event_res))

endmodule

bind remote_command_frame_parser_core rcfp_checker u_rcfp_checker (.*);
